[src/twaddr_pkg.sv]
// ----------------------------------------------------------------------------
// Twiddled texel address generator package
// Shared widths, register indexes and format codes.
// ----------------------------------------------------------------------------
package twaddr_pkg;

  localparam int COORD_W          = 10;
  localparam int LOG2_W           = 4;
  localparam int BYTE_ADDR_W      = 24;
  localparam int QUAD_W           = 2;
  localparam int MIP_W            = 21;
  localparam int FMT_W            = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 24;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 32;

  localparam int DEF_ADDR_BITS     = 24;
  localparam int DEF_MAX_LOG2_SIZE = 10;
  localparam int MIN_LOG2_SIZE     = 3;
  localparam int VQ_CODEBOOK_BYTES = 2048;

  localparam logic [LOG2_W-1:0]      RST_LOG2_SIZE = 4'd3;
  localparam logic [BYTE_ADDR_W-1:0] BASE_ALIGN_MASK = 24'hFFFFF8;

  localparam logic [FMT_W-1:0] FMT_DIRECT  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_VQ      = 2'd1;
  localparam logic [FMT_W-1:0] FMT_PALETTE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_WIDTH   = 3'd0,
    CFG_LOG2_HEIGHT  = 3'd1,
    CFG_TEXEL_FORMAT = 3'd2,
    CFG_LINEAR       = 3'd3,
    CFG_BASE_ADDRESS = 3'd4,
    CFG_MIP_OFFSET   = 3'd5
  } cfg_idx_t;

endpackage

[src/twiddled_texel_address_gen_top.sv]
// ----------------------------------------------------------------------------
// Twiddled texel address generator
// Takes one texel coordinate per transaction and returns the byte address of
// the texel, VQ code byte or palette index, plus the VQ codebook word select.
// The block accepts one transaction per clock unless a stalled output backs
// up the pipe, and passes each through three register stages: coordinate
// wrap and VQ halving, Morton or row-major index, and the final address add.
// The last stage is the output register, and a stalled output only holds the
// stages that have no free slot behind it. The user must write configuration through
// the plain write port while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module twiddled_texel_address_gen_top #(
  parameter int ADDR_BITS     = twaddr_pkg::DEF_ADDR_BITS,
  parameter int MAX_LOG2_SIZE = twaddr_pkg::DEF_MAX_LOG2_SIZE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [twaddr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twaddr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: tex_x[9:0], tex_y[19:10], zero fill.
  input  logic [twaddr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: byte_address[23:0], quad_select[25:24], zero fill.
  output logic [twaddr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import twaddr_pkg::*;

  localparam int IDX_W    = COORD_W + MAX_LOG2_SIZE;
  localparam int MORTON_W = (COORD_W < MAX_LOG2_SIZE) ? COORD_W : MAX_LOG2_SIZE;

  logic [LOG2_W-1:0]      cfg_lw_r;
  logic [LOG2_W-1:0]      cfg_lh_r;
  logic [FMT_W-1:0]       cfg_fmt_r;
  logic                   cfg_linear_r;
  logic [BYTE_ADDR_W-1:0] cfg_base_r;
  logic [MIP_W-1:0]       cfg_mip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lw_r     <= RST_LOG2_SIZE;
      cfg_lh_r     <= RST_LOG2_SIZE;
      cfg_fmt_r    <= FMT_DIRECT;
      cfg_linear_r <= 1'b0;
      cfg_base_r   <= '0;
      cfg_mip_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOG2_WIDTH:   cfg_lw_r     <= cfg_wdata[LOG2_W-1:0];
        CFG_LOG2_HEIGHT:  cfg_lh_r     <= cfg_wdata[LOG2_W-1:0];
        CFG_TEXEL_FORMAT: cfg_fmt_r    <= cfg_wdata[FMT_W-1:0];
        CFG_LINEAR:       cfg_linear_r <= cfg_wdata[0];
        CFG_BASE_ADDRESS: cfg_base_r   <= cfg_wdata[BYTE_ADDR_W-1:0];
        CFG_MIP_OFFSET:   cfg_mip_r    <= cfg_wdata[MIP_W-1:0];
        default: ;
      endcase
    end
  end

  logic fmt_vq;
  logic fmt_pal;
  logic use_linear;
  assign fmt_vq     = (cfg_fmt_r == FMT_VQ);
  assign fmt_pal    = (cfg_fmt_r == FMT_PALETTE);
  assign use_linear = cfg_linear_r && !fmt_pal;

  // Pipeline flow control.
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s2_adv;
  logic s1_adv;

  assign out_adv   = !out_valid_r || out_tready;
  assign s2_adv    = !s2_valid_r || out_adv;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_tready = s1_adv;

  // Stage 1: size clamp, coordinate wrap, VQ halving.
  logic [LOG2_W-1:0]  lw_cl;
  logic [LOG2_W-1:0]  lh_cl;
  logic [COORD_W-1:0] x_in;
  logic [COORD_W-1:0] y_in;
  logic [COORD_W-1:0] x_wrap;
  logic [COORD_W-1:0] y_wrap;
  logic [COORD_W-1:0] s1_x_nxt;
  logic [COORD_W-1:0] s1_y_nxt;
  logic [LOG2_W-1:0]  s1_lw_nxt;
  logic [LOG2_W-1:0]  s1_lh_nxt;
  logic [QUAD_W-1:0]  s1_quad_nxt;

  assign x_in = in_tdata[COORD_W-1:0];
  assign y_in = in_tdata[2*COORD_W-1:COORD_W];

  always_comb begin
    priority if (cfg_lw_r < LOG2_W'(MIN_LOG2_SIZE)) begin
      lw_cl = LOG2_W'(MIN_LOG2_SIZE);
    end else if (cfg_lw_r > LOG2_W'(MAX_LOG2_SIZE)) begin
      lw_cl = LOG2_W'(MAX_LOG2_SIZE);
    end else begin
      lw_cl = cfg_lw_r;
    end
    priority if (cfg_lh_r < LOG2_W'(MIN_LOG2_SIZE)) begin
      lh_cl = LOG2_W'(MIN_LOG2_SIZE);
    end else if (cfg_lh_r > LOG2_W'(MAX_LOG2_SIZE)) begin
      lh_cl = LOG2_W'(MAX_LOG2_SIZE);
    end else begin
      lh_cl = cfg_lh_r;
    end
  end

  always_comb begin
    for (int k = 0; k < COORD_W; k++) begin
      x_wrap[k] = x_in[k] && (k < int'(lw_cl));
      y_wrap[k] = y_in[k] && (k < int'(lh_cl));
    end
  end

  always_comb begin
    if (fmt_vq) begin
      s1_x_nxt    = x_wrap >> 1;
      s1_y_nxt    = y_wrap >> 1;
      s1_lw_nxt   = lw_cl - LOG2_W'(1);
      s1_lh_nxt   = lh_cl - LOG2_W'(1);
      s1_quad_nxt = {x_wrap[0], y_wrap[0]};
    end else begin
      s1_x_nxt    = x_wrap;
      s1_y_nxt    = y_wrap;
      s1_lw_nxt   = lw_cl;
      s1_lh_nxt   = lh_cl;
      s1_quad_nxt = '0;
    end
  end

  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;
  logic [LOG2_W-1:0]  s1_lw_r;
  logic [LOG2_W-1:0]  s1_lh_r;
  logic [QUAD_W-1:0]  s1_quad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_x_r    <= s1_x_nxt;
      s1_y_r    <= s1_y_nxt;
      s1_lw_r   <= s1_lw_nxt;
      s1_lh_r   <= s1_lh_nxt;
      s1_quad_r <= s1_quad_nxt;
    end
  end

  // Stage 2: Morton or row-major index and the constant address offset.
  logic [LOG2_W-1:0]    m_side;
  logic [IDX_W-1:0]     inner;
  logic [IDX_W-1:0]     hi_src;
  logic [IDX_W-1:0]     tw_idx;
  logic [IDX_W-1:0]     lin_idx;
  logic [IDX_W-1:0]     s2_idx_nxt;
  logic [ADDR_BITS-1:0] s2_off_nxt;

  assign m_side = (s1_lw_r < s1_lh_r) ? s1_lw_r : s1_lh_r;

  always_comb begin
    inner = '0;
    for (int k = 0; k < MORTON_W; k++) begin
      inner[2*k]   = s1_y_r[k] && (k < int'(m_side));
      inner[2*k+1] = s1_x_r[k] && (k < int'(m_side));
    end
  end

  assign hi_src  = (s1_lw_r > s1_lh_r) ? (IDX_W'(s1_x_r) >> m_side)
                                       : (IDX_W'(s1_y_r) >> m_side);
  assign tw_idx  = (hi_src << {m_side, 1'b0}) | inner;
  assign lin_idx = (IDX_W'(s1_y_r) << s1_lw_r) | IDX_W'(s1_x_r);

  assign s2_idx_nxt = use_linear ? lin_idx : tw_idx;
  assign s2_off_nxt = ADDR_BITS'(cfg_base_r & BASE_ALIGN_MASK)
                    + (fmt_vq ? ADDR_BITS'(VQ_CODEBOOK_BYTES) : '0)
                    + (use_linear ? '0 : ADDR_BITS'(cfg_mip_r));

  logic [IDX_W-1:0]     s2_idx_r;
  logic [ADDR_BITS-1:0] s2_off_r;
  logic [QUAD_W-1:0]    s2_quad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_idx_r  <= s2_idx_nxt;
      s2_off_r  <= s2_off_nxt;
      s2_quad_r <= s1_quad_r;
    end
  end

  // Stage 3: scale by texel size and add the offset.
  logic [ADDR_BITS-1:0]   scaled_idx;
  logic [ADDR_BITS-1:0]   addr_sum;
  logic [BYTE_ADDR_W-1:0] out_addr_r;
  logic [QUAD_W-1:0]      out_quad_r;

  assign scaled_idx = (fmt_vq || fmt_pal) ? ADDR_BITS'(s2_idx_r)
                                          : ADDR_BITS'({s2_idx_r, 1'b0});
  assign addr_sum   = s2_off_r + scaled_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_addr_r <= BYTE_ADDR_W'(addr_sum);
      out_quad_r <= s2_quad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-BYTE_ADDR_W-QUAD_W){1'b0}}, out_quad_r, out_addr_r};

endmodule

[verif/twiddled_texel_address_gen_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twiddled texel address checker
// Watches the configuration port and both stream channels of the address
// generator. Every accepted coordinate is turned into an expected address and
// quad select using a local copy of the registers, and every accepted result
// is compared against the oldest expected entry.
// ----------------------------------------------------------------------------
module twiddled_texel_address_gen_checker
  import twaddr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            mismatches,
  output int unsigned            pending
);

  typedef struct packed {
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [QUAD_W-1:0]      quad_select;
  } texel_addr_t;

  logic [LOG2_W-1:0]      log2_width_q;
  logic [LOG2_W-1:0]      log2_height_q;
  logic [FMT_W-1:0]       texel_format_q;
  logic                   linear_q;
  logic [BYTE_ADDR_W-1:0] base_address_q;
  logic [MIP_W-1:0]       mip_offset_q;

  texel_addr_t addr_fifo[$];
  int unsigned err_cnt = 0;

  function automatic int unsigned sat_log2(input logic [LOG2_W-1:0] v);
    if (v < MIN_LOG2_SIZE) return MIN_LOG2_SIZE;
    if (v > DEF_MAX_LOG2_SIZE) return DEF_MAX_LOG2_SIZE;
    return v;
  endfunction

  // Morton index inside square chunks of the smaller side; chunks row by row.
  function automatic logic [63:0] morton_index(input logic [63:0] cx, input logic [63:0] cy,
                                               input int unsigned lw, input int unsigned lh);
    int unsigned m;
    int unsigned k;
    logic [63:0] inner;
    logic [63:0] chunk;
    m = (lw < lh) ? lw : lh;
    inner = '0;
    for (k = 0; k < 16; k++) begin
      if (k < m) begin
        inner[2*k]   = cy[k];
        inner[2*k+1] = cx[k];
      end
    end
    chunk = ((cy >> m) << (lw - m)) + (cx >> m);
    return (chunk << (2 * m)) + inner;
  endfunction

  function automatic texel_addr_t texel_address(input logic [COORD_W-1:0] tex_x,
                                                input logic [COORD_W-1:0] tex_y);
    int unsigned lw;
    int unsigned lh;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] base;
    logic [63:0] mip;
    logic [63:0] addr;
    texel_addr_t r;
    lw   = sat_log2(log2_width_q);
    lh   = sat_log2(log2_height_q);
    x    = 64'(tex_x) & ((64'd1 << lw) - 64'd1);
    y    = 64'(tex_y) & ((64'd1 << lh) - 64'd1);
    base = 64'(base_address_q & BASE_ALIGN_MASK);
    mip  = 64'(mip_offset_q);
    r.quad_select = '0;
    case (texel_format_q)
      FMT_VQ: begin
        r.quad_select = {x[0], y[0]};
        base = base + 64'(VQ_CODEBOOK_BYTES);
        if (linear_q) begin
          addr = base + ((y >> 1) << (lw - 1)) + (x >> 1);
        end else begin
          addr = base + mip + morton_index(x >> 1, y >> 1, lw - 1, lh - 1);
        end
      end
      FMT_PALETTE: begin
        addr = base + mip + morton_index(x, y, lw, lh);
      end
      default: begin
        if (linear_q) begin
          addr = base + 64'd2 * ((y << lw) + x);
        end else begin
          addr = base + mip + 64'd2 * morton_index(x, y, lw, lh);
        end
      end
    endcase
    addr = addr & ((64'd1 << DEF_ADDR_BITS) - 64'd1);
    r.byte_address = addr[BYTE_ADDR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    texel_addr_t want;
    texel_addr_t got;
    if (!rst_n) begin
      log2_width_q   <= RST_LOG2_SIZE;
      log2_height_q  <= RST_LOG2_SIZE;
      texel_format_q <= FMT_DIRECT;
      linear_q       <= 1'b0;
      base_address_q <= '0;
      mip_offset_q   <= '0;
      addr_fifo.delete();
      pending        <= 0;
    end else begin
      // A coordinate accepted on the same edge as a write still sees the old value.
      if (in_tvalid && in_tready) begin
        addr_fifo.push_back(texel_address(in_tdata[COORD_W-1:0],
                                          in_tdata[2*COORD_W-1:COORD_W]));
      end
      if (out_tvalid && out_tready) begin
        got.byte_address = out_tdata[BYTE_ADDR_W-1:0];
        got.quad_select  = out_tdata[BYTE_ADDR_W+QUAD_W-1:BYTE_ADDR_W];
        if (addr_fifo.size() == 0) begin
          $error("result transaction with no pending coordinate: byte_address %h",
                 got.byte_address);
          err_cnt++;
        end else begin
          want = addr_fifo.pop_front();
          if (got.byte_address !== want.byte_address) begin
            $error("byte_address expected %h actual %h", want.byte_address, got.byte_address);
            err_cnt++;
          end
          if (got.quad_select !== want.quad_select) begin
            $error("quad_select expected %0d actual %0d", want.quad_select, got.quad_select);
            err_cnt++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LOG2_WIDTH:   log2_width_q   <= cfg_wdata[LOG2_W-1:0];
          CFG_LOG2_HEIGHT:  log2_height_q  <= cfg_wdata[LOG2_W-1:0];
          CFG_TEXEL_FORMAT: texel_format_q <= cfg_wdata[FMT_W-1:0];
          CFG_LINEAR:       linear_q       <= cfg_wdata[0];
          CFG_BASE_ADDRESS: base_address_q <= cfg_wdata[BYTE_ADDR_W-1:0];
          CFG_MIP_OFFSET:   mip_offset_q   <= cfg_wdata[MIP_W-1:0];
          default: ;
        endcase
      end
      pending <= addr_fifo.size();
    end
    mismatches <= err_cnt;
  end

endmodule

[verif/tb_twiddled_texel_address_gen_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twiddled texel address generator testbench
// Drives coordinates through the stream input under a series of register
// settings, starting with corner cases and continuing with random settings
// and coordinates, while both channels idle at random. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_twiddled_texel_address_gen_top;
  import twaddr_pkg::*;

  localparam logic [FMT_W-1:0] FMT_RESERVED = 2'd3;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned RANDOM_PHASES  = 26;
  localparam int unsigned PHASE_TEXELS   = 25;
  localparam int unsigned HOLD_AT        = 120;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_SLACK    = 4;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_LOG2_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned texels_sent = 0;
  bit          no_idle = 1'b0;
  bit          hold_done = 1'b0;

  twiddled_texel_address_gen_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  twiddled_texel_address_gen_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off once traffic is going.
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (!hold_done && texels_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Keeps the write enable high across back-to-back writes; the caller lowers it.
  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_texture(input logic [CFG_DATA_W-1:0] lw, input logic [CFG_DATA_W-1:0] lh,
                              input logic [CFG_DATA_W-1:0] fmt, input logic [CFG_DATA_W-1:0] lin,
                              input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] mip);
    put_reg(CFG_LOG2_WIDTH, lw);
    put_reg(CFG_LOG2_HEIGHT, lh);
    put_reg(CFG_TEXEL_FORMAT, fmt);
    put_reg(CFG_LINEAR, lin);
    put_reg(CFG_BASE_ADDRESS, base);
    put_reg(CFG_MIP_OFFSET, mip);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_texel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-2*COORD_W){1'b0}}, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    texels_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic logic [LOG2_W-1:0] rand_log2();
    if ($urandom_range(0, 9) == 0) return LOG2_W'($urandom_range(0, 15));
    return LOG2_W'($urandom_range(MIN_LOG2_SIZE, DEF_MAX_LOG2_SIZE));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COORD_W'($urandom_range(0, 1023));
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [CFG_DATA_W-1:0] noise;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 8x8 direct twiddled, coordinates wrap.
    send_texel(10'd0, 10'd0);
    send_texel(10'd7, 10'd7);
    send_texel(10'd1023, 10'd1023);
    send_texel(10'd5, 10'd2);
    drain();

    // Largest direct linear texture, unaligned base, overflow wraps, mip ignored.
    load_texture(24'd10, 24'd10, 24'(FMT_DIRECT), 24'd1, 24'hFFFFFF, 24'h1FFFFF);
    send_texel(10'd1023, 10'd1023);
    send_texel(10'd0, 10'd0);
    send_texel(10'd1, 10'd0);
    drain();

    // Tall VQ twiddled texture: several chunks stacked vertically.
    load_texture(24'd3, 24'd10, 24'(FMT_VQ), 24'd0, 24'h123458, 24'h1FFFFF);
    send_texel(10'd7, 10'd1023);
    send_texel(10'd0, 10'd0);
    send_texel(10'd1, 10'd1);
    send_texel(10'd6, 10'd513);
    drain();

    // Wide VQ linear texture.
    load_texture(24'd10, 24'd3, 24'(FMT_VQ), 24'd1, 24'hFFF800, 24'h000000);
    send_texel(10'd1023, 10'd7);
    send_texel(10'd2, 10'd1);
    send_texel(10'd1, 10'd2);
    drain();

    // Palette with linear set, size exponents past both ends.
    load_texture(24'd15, 24'd0, 24'(FMT_PALETTE), 24'd1, 24'hABCDEF, 24'h0F0F0F);
    send_texel(10'd1023, 10'd1023);
    send_texel(10'd0, 10'd5);
    drain();

    // Reserved format behaves as direct.
    load_texture(24'd2, 24'd11, 24'(FMT_RESERVED), 24'd0, 24'h000008, 24'h100000);
    send_texel(10'd3, 10'd1023);
    send_texel(10'd1023, 10'd0);
    drain();

    // Saturated VQ sizes with full register words.
    load_texture(24'hFFFFF0, 24'hFFFFFF, 24'hFFFFFD, 24'hFFFFFE, 24'h000007, 24'hFFFFFF);
    send_texel(10'd1023, 10'd1022);
    send_texel(10'd512, 10'd257);
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase % 4 == 3);
      noise = CFG_DATA_W'($urandom);
      load_texture({noise[CFG_DATA_W-1:LOG2_W], rand_log2()},
                   {noise[LOG2_W +: CFG_DATA_W-LOG2_W], rand_log2()},
                   {noise[CFG_DATA_W-1:FMT_W], FMT_W'($urandom_range(0, 3))},
                   CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom));
      for (n = 0; n < PHASE_TEXELS; n++) begin
        send_texel(rand_coord(), rand_coord());
      end
      drain();
    end
    no_idle = 1'b0;

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
